FILE: src/s1h_pkg.sv
// shared types and constants for the sha-1 stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package s1h_pkg;
  localparam logic [1:0] ACT_DATA   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_ABORT  = 2'd2;

  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

FILE: src/sha1_stream_hasher.sv
// sha-1 stream hasher top level: byte buffer memory, round unit, digest output
// depends on s1h_pkg
//
// usage:
//   input channel (valid/ready, action + data_byte): action 0 appends a byte,
//   1 finishes the message and returns the digest, 2 aborts the message.
//   output channel (valid/ready): five items H0..H4, last_word on H4.
// flow control:
//   a data byte is taken while idle, except the 64th byte of a block, which
//   starts the compression: a read-start state, 64 byte loads from the
//   byte memory (one byte port), 80 rounds, one per cycle, and a fold state,
//   and ready stays low until the fold is done.
//   finish pads the buffer one byte per cycle (up to 64), compresses one or
//   two blocks the same way, then presents the five digest words.
// reset clears chaining words, counters and the message flag; no clearing
// pass is needed. a stalled receiver holds the current digest word and the
// block takes no new item until all five words are taken.
`timescale 1ns / 1ps
`default_nettype none
module sha1_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  s1h_pkg::state_t state;

  // block buffer and schedule window memories
  logic [7:0]  buf_mem [64];
  logic [7:0]  buf_rd;
  logic [5:0]  buf_waddr, buf_raddr;
  logic [7:0]  buf_wdata;
  logic        buf_we;

  logic [31:0] win [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        open;
  logic        finishing;
  logic        second;  // the extra length block is being padded or hashed
  logic [6:0]  rnd;
  logic [5:0]  ld;      // byte counter while loading words
  logic [5:0]  pad_pos;
  logic [23:0] wacc;
  logic [2:0]  widx;

  assign ready = (state == s1h_pkg::ST_IDLE);

  // byte memory port, registered read
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    buf_rd <= buf_mem[buf_raddr];
  end

  logic [63:0] bits;
  assign bits = {msg_bytes, 3'b000};

  always_comb begin
    buf_we = 1'b0;
    buf_waddr = fill;
    buf_wdata = data_byte;
    buf_raddr = ld;
    if (state == s1h_pkg::ST_IDLE && valid && action == s1h_pkg::ACT_DATA) begin
      buf_we = 1'b1;
      buf_waddr = open ? fill : 6'd0;
    end else if (state == s1h_pkg::ST_PAD) begin
      buf_we = 1'b1;
      buf_waddr = pad_pos;
      if (pad_pos == fill && !second) buf_wdata = s1h_pkg::PAD_BYTE;
      else if (pad_pos >= 6'd56 && (!second ? fill < 6'd56 : 1'b1) &&
               !(pad_pos == fill && !second))
        buf_wdata = bits[8*(63-pad_pos) +: 8];
      else buf_wdata = 8'd0;
      if (!second && fill >= 6'd56 && pad_pos >= 6'd56 && pad_pos != fill)
        buf_wdata = 8'd0;
    end
  end

  // round function
  logic [31:0] f, k, w, sum;
  logic [31:0] wnew;
  assign wnew = {win[13] ^ win[8] ^ win[2] ^ win[0]} << 1 |
                {31'd0, (win[13][31] ^ win[8][31] ^ win[2][31] ^ win[0][31])};
  always_comb begin
    // the window rotates every round; entry 0 holds the word for rounds 0-15
    w = (rnd < 7'd16) ? win[0] : wnew;
    if (rnd < 7'd20) begin
      f = d ^ (b & (c ^ d)); k = s1h_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = s1h_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (b & (c | d)) | (c & d); k = s1h_pkg::K2;
    end else begin
      f = b ^ c ^ d; k = s1h_pkg::K3;
    end
    sum = {a[26:0], a[31:27]} + f + e + k + w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s1h_pkg::ST_IDLE;
      for (int i = 0; i < 5; i++) h[i] <= 32'd0;
      fill <= 6'd0;
      msg_bytes <= 61'd0;
      open <= 1'b0;
      finishing <= 1'b0;
      second <= 1'b0;
      rnd <= 7'd0;
      ld <= 6'd0;
      pad_pos <= 6'd0;
      widx <= 3'd0;
    end else begin
      case (state)
        s1h_pkg::ST_IDLE: begin
          if (valid) begin
            case (action)
              s1h_pkg::ACT_DATA: begin
                if (!open) begin
                  h[0] <= s1h_pkg::H_INIT0; h[1] <= s1h_pkg::H_INIT1;
                  h[2] <= s1h_pkg::H_INIT2; h[3] <= s1h_pkg::H_INIT3;
                  h[4] <= s1h_pkg::H_INIT4;
                  msg_bytes <= 61'd1;
                  open <= 1'b1;
                  fill <= 6'd1;
                end else begin
                  msg_bytes <= msg_bytes + 61'd1;
                  fill <= fill + 6'd1;
                  if (fill == 6'd63) begin
                    finishing <= 1'b0;
                    ld <= 6'd0;
                    state <= s1h_pkg::ST_WAIT;
                  end
                end
              end
              s1h_pkg::ACT_FINISH: begin
                widx <= 3'd0;
                if (open) begin
                  finishing <= 1'b1;
                  second <= 1'b0;
                  pad_pos <= fill;
                  state <= s1h_pkg::ST_PAD;
                end else state <= s1h_pkg::ST_EMIT;
              end
              s1h_pkg::ACT_ABORT: open <= 1'b0;
              default: ;
            endcase
          end
        end
        s1h_pkg::ST_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            ld <= 6'd0;
            state <= s1h_pkg::ST_WAIT;
          end
        end
        s1h_pkg::ST_WAIT: begin  // first read issued
          ld <= ld + 6'd1;
          state <= s1h_pkg::ST_LOAD;
        end
        s1h_pkg::ST_LOAD: begin
          wacc <= {wacc[15:0], buf_rd};
          if (ld[1:0] == 2'd0) win[ld[5:2] - 4'd1] <= {wacc, buf_rd};
          ld <= ld + 6'd1;
          if (ld == 6'd0) begin
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            rnd <= 7'd0;
            state <= s1h_pkg::ST_ROUND;
          end
        end
        s1h_pkg::ST_ROUND: begin
          if (rnd < 7'd16) begin
            for (int i = 0; i < 15; i++) win[i] <= win[i+1];
            win[15] <= win[0];
          end else begin
            for (int i = 0; i < 15; i++) win[i] <= win[i+1];
            win[15] <= wnew;
          end
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= sum;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= s1h_pkg::ST_ADD;
        end
        s1h_pkg::ST_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          fill <= 6'd0;
          if (!finishing) state <= s1h_pkg::ST_IDLE;
          else if (!second && fill >= 6'd56) begin
            second <= 1'b1;
            pad_pos <= 6'd0;
            state <= s1h_pkg::ST_PAD;
          end else begin
            open <= 1'b0;
            finishing <= 1'b0;
            widx <= 3'd0;
            state <= s1h_pkg::ST_EMIT;
          end
        end
        s1h_pkg::ST_EMIT: begin
          if (out_ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd4) state <= s1h_pkg::ST_IDLE;
          end
        end
        default: state <= s1h_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_valid = (state == s1h_pkg::ST_EMIT);
  assign word_index = widx;
  assign last_word = (widx == 3'd4);
  always_comb begin
    case (widx)
      3'd0: digest_word = h[0];
      3'd1: digest_word = h[1];
      3'd2: digest_word = h[2];
      3'd3: digest_word = h[3];
      3'd4: digest_word = h[4];
      default: digest_word = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/s1h_checker.sv
// port-level checks for the sha-1 stream hasher
// depends on sha1_stream_hasher ports only
`timescale 1ns / 1ps
`default_nettype none
module s1h_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("output item changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word does not match index");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && ready))
    else $error("input open while digest pending");
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words out of sequence");
endmodule
bind sha1_stream_hasher s1h_checker u_s1h_checker (.*);
`default_nettype wire

FILE: dv/sha1_digest_checker.sv
// checker for the sha-1 stream hasher: watches both channels, keeps its own sha-1
// model of the message state and compares every digest word; depends on s1h_pkg
`timescale 1ns / 1ps
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic [31:0]  chain [5];
  logic [7:0]   blk [64];
  logic [6:0]   fill;
  logic [60:0]  msg_len;
  logic         msg_open;
  digest_item_t digest_q [$];

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, sum;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) wt = w[t];
      else begin
        wt = rotl(w[(t-3)&15] ^ w[(t-8)&15] ^ w[(t-14)&15] ^ w[t&15], 1);
        w[t&15] = wt;
      end
      if (t < 20) begin f = d ^ (b & (c ^ d)); k = s1h_pkg::K0; end
      else if (t < 40) begin f = b ^ c ^ d; k = s1h_pkg::K1; end
      else if (t < 60) begin f = (b & (c | d)) | (c & d); k = s1h_pkg::K2; end
      else begin f = b ^ c ^ d; k = s1h_pkg::K3; end
      sum = rotl(a, 5) + f + e + k + wt;
      e = d; d = c; c = rotl(b, 30); b = a; a = sum;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic close_message();
    logic [63:0] bits;
    int pos;
    bits = {msg_len, 3'b000};
    pos = fill[5:0];
    blk[pos] = s1h_pkg::PAD_BYTE;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin blk[pos] = 8'h00; pos++; end
      compress();
      pos = 0;
    end
    while (pos < 56) begin blk[pos] = 8'h00; pos++; end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    fill = '0;
    msg_open = 1'b0;
  endtask

  task automatic accept_item(logic [1:0] act, logic [7:0] byte_in);
    digest_item_t it;
    case (act)
      s1h_pkg::ACT_DATA: begin
        if (!msg_open) begin
          chain[0] = s1h_pkg::H_INIT0; chain[1] = s1h_pkg::H_INIT1;
          chain[2] = s1h_pkg::H_INIT2; chain[3] = s1h_pkg::H_INIT3;
          chain[4] = s1h_pkg::H_INIT4;
          fill = '0; msg_len = '0; msg_open = 1'b1;
        end
        blk[fill[5:0]] = byte_in;
        fill++;
        msg_len++;
        if (fill >= 64) begin
          compress();
          fill = '0;
        end
      end
      s1h_pkg::ACT_FINISH: begin
        if (msg_open) close_message();
        for (int i = 0; i < 5; i++) begin
          it.word = chain[i]; it.index = 3'(i); it.last = (i == 4);
          digest_q.push_back(it);
        end
      end
      s1h_pkg::ACT_ABORT: msg_open = 1'b0;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst) begin
      for (int i = 0; i < 5; i++) chain[i] = '0;
      fill = '0; msg_len = '0; msg_open = 1'b0;
      digest_q.delete();
      fail_count = 0;
      words_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h idx %0d", digest_word, word_index);
        end else begin
          exp_item = digest_q.pop_front();
          if (exp_item.word !== digest_word || exp_item.index !== word_index ||
              exp_item.last !== last_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                       exp_item.word, exp_item.index, exp_item.last,
                       digest_word, word_index, last_word);
          end
        end
      end
      if (valid && ready) accept_item(action, data_byte);
      words_pending = digest_q.size();
    end
  end
endmodule

FILE: dv/tb_sha1_stream_hasher.sv
// testbench top for the sha-1 stream hasher: drives byte/finish/abort items
// with random gaps and receiver stalls; depends on s1h_pkg and the checker
`timescale 1ns / 1ps
module tb_sha1_stream_hasher;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [1:0]  action = s1h_pkg::ACT_DATA;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          words_pending;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  localparam int CYCLE_LIMIT = 2000000;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sha1_stream_hasher dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .action(action),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  sha1_digest_checker checker_i (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .action(action),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  // sender: one item, random gap unless in a calm stretch
  task automatic send_item(logic [1:0] act, logic [7:0] b);
    if (!calm && $urandom_range(99) < 22) begin
      valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 22) @(posedge clk);
    end
    valid <= 1'b1;
    action <= act;
    data_byte <= b;
    @(posedge clk);
    while (!ready) @(posedge clk);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(s1h_pkg::ACT_DATA, 8'($urandom));
  endtask

  // receiver: random stalls, one long hold-off when asked
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int len, pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: finish after reset, extremes, two-block padding, abort
    send_item(s1h_pkg::ACT_FINISH, 8'h00);
    send_item(s1h_pkg::ACT_ABORT, 8'h00);
    send_item(2'd3, 8'hFF);
    send_item(s1h_pkg::ACT_DATA, 8'h00);
    send_item(s1h_pkg::ACT_DATA, 8'hFF);
    send_item(s1h_pkg::ACT_DATA, 8'hA5);
    send_item(s1h_pkg::ACT_FINISH, 8'h5A);
    send_item(s1h_pkg::ACT_FINISH, 8'h00);
    send_item(s1h_pkg::ACT_DATA, 8'h80);
    send_item(s1h_pkg::ACT_ABORT, 8'hFF);
    send_item(s1h_pkg::ACT_FINISH, 8'h00);
    send_item(s1h_pkg::ACT_FINISH, 8'h00);
    send_message(56); send_item(s1h_pkg::ACT_FINISH, 8'h00);

    // receiver holds off while the sender waits behind the pending digest
    hold_off = 1'b1;
    fork
      begin repeat (400) @(posedge clk); hold_off = 1'b0; end
      begin
        send_message(3); send_item(s1h_pkg::ACT_FINISH, 8'h00);
        send_item(s1h_pkg::ACT_FINISH, 8'h00); send_item(s1h_pkg::ACT_DATA, 8'h11);
      end
    join

    // calm stretch with no idling at all, one exact full block
    calm = 1'b1;
    send_item(s1h_pkg::ACT_FINISH, 8'h00);
    send_message(64); send_item(s1h_pkg::ACT_FINISH, 8'h00);
    calm = 1'b0;

    // random: short messages with some noise
    for (int n = 0; n < 5; n++) begin
      len = $urandom_range(0, 3);
      send_message(len);
      pick = $urandom_range(99);
      if (pick < 12) send_item(s1h_pkg::ACT_ABORT, 8'($urandom));
      else if (pick < 16) send_item(2'd3, 8'($urandom));
      send_item(s1h_pkg::ACT_FINISH, 8'($urandom));
    end
    valid <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
